@@ rtl/olid_pkg.sv @@
// package for the ordered list insert/delete block
// holds sizes, command and status codes, sequencer states and shared structs
// no dependencies
package olid_pkg;

    localparam int CAPACITY = 16;
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int DATA_W   = 32;
    localparam int CMD_W    = 2;
    localparam int STAT_W   = 3;

    localparam logic [CMD_W-1:0] CMD_INSERT  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_DELETE  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_DISPLAY = 2'd2;

    typedef enum logic [STAT_W-1:0] {
        ST_INSERTED  = 3'd0,
        ST_FULL      = 3'd1,
        ST_DELETED   = 3'd2,
        ST_NOT_FOUND = 3'd3,
        ST_EMPTY     = 3'd4,
        ST_ELEMENT   = 3'd5
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_REPORT,
        S_DEL_RD,
        S_DEL_CMP,
        S_SHF_RD,
        S_SHF_WR,
        S_DISP_RD,
        S_DISP_EMIT
    } state_t;

    typedef struct packed {
        logic                     valid;
        status_t                  status;
        logic signed [DATA_W-1:0] element;
        logic                     last;
    } beat_t;

    typedef struct packed {
        logic             match;
        logic             at_end;
        logic [IDX_W-1:0] idx_inc;
    } unit_res_t;

endpackage

@@ rtl/olid_unit.sv @@
// shared compare and index unit used by the sequencer in its compare, shift-write and display-emit states
// depends on olid_pkg
module olid_unit
    import olid_pkg::*;
(
    input  logic signed [DATA_W-1:0] a,
    input  logic signed [DATA_W-1:0] b,
    input  logic [IDX_W-1:0]         idx,
    input  logic [CNT_W-1:0]         count,
    output unit_res_t                res
);

    always_comb
    begin
        res.match   = (a == b);
        res.at_end  = ((CNT_W'(idx) + CNT_W'(1)) == count);
        res.idx_inc = idx + IDX_W'(1);
    end

endmodule

@@ rtl/olid_outreg.sv @@
// output register between the sequencer and the result channel
// depends on olid_pkg
module olid_outreg
    import olid_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  beat_t                    emit,
    output logic                     emit_ready,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic [STAT_W-1:0]        status,
    output logic signed [DATA_W-1:0] element,
    output logic                     last
);

    logic                     valid_reg;
    status_t                  status_reg;
    logic signed [DATA_W-1:0] element_reg;
    logic                     last_reg;

    assign emit_ready = !valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (emit_ready)
        begin
            valid_reg <= emit.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit_ready && emit.valid)
        begin
            status_reg  <= emit.status;
            element_reg <= emit.element;
            last_reg    <= emit.last;
        end
    end

    assign out_valid = valid_reg;
    assign status    = status_reg;
    assign element   = element_reg;
    assign last      = last_reg;

endmodule

@@ rtl/olid_seq.sv @@
// sequencer and entry memory of the ordered list
// depends on olid_pkg and olid_unit
module olid_seq
    import olid_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic [CMD_W-1:0]         command,
    input  logic signed [DATA_W-1:0] value,
    input  logic                     emit_ready,
    output beat_t                    emit
);

    logic signed [DATA_W-1:0] mem [CAPACITY];

    state_t                   state_reg, state_next;
    logic [IDX_W-1:0]         idx_reg, idx_next;
    logic [CNT_W-1:0]         count_reg, count_next;
    status_t                  report_reg, report_next;
    logic signed [DATA_W-1:0] value_reg;
    logic signed [DATA_W-1:0] rdata_reg;

    logic                     accept;
    logic                     full;
    logic                     rd_en;
    logic                     wr_en;
    logic [IDX_W-1:0]         wr_addr;
    logic signed [DATA_W-1:0] wr_data;
    unit_res_t                ures;

    assign accept = in_valid && !in_stall;
    assign full   = (count_reg == CNT_W'(CAPACITY));

    olid_unit u_unit (
        .a     (rdata_reg),
        .b     (value_reg),
        .idx   (idx_reg),
        .count (count_reg),
        .res   (ures)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    priority if (command == CMD_INSERT)
                        state_next = S_REPORT;
                    else if (command == CMD_DELETE)
                        state_next = (count_reg == '0) ? S_REPORT : S_DEL_RD;
                    else if (command == CMD_DISPLAY)
                        state_next = (count_reg == '0) ? S_REPORT : S_DISP_RD;
                    else
                        state_next = S_IDLE;
                end
            end
            S_REPORT:
            begin
                if (emit_ready)
                    state_next = S_IDLE;
            end
            S_DEL_RD:
                state_next = S_DEL_CMP;
            S_DEL_CMP:
            begin
                if (ures.at_end)
                    state_next = S_REPORT;
                else if (ures.match)
                    state_next = S_SHF_RD;
                else
                    state_next = S_DEL_RD;
            end
            S_SHF_RD:
                state_next = S_SHF_WR;
            S_SHF_WR:
            begin
                if (ures.at_end)
                    state_next = S_REPORT;
                else
                    state_next = S_SHF_RD;
            end
            S_DISP_RD:
                state_next = S_DISP_EMIT;
            S_DISP_EMIT:
            begin
                if (emit_ready)
                    state_next = ures.at_end ? S_IDLE : S_DISP_RD;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        in_stall     = 1'b1;
        idx_next     = idx_reg;
        count_next   = count_reg;
        report_next  = report_reg;
        rd_en        = 1'b0;
        wr_en        = 1'b0;
        wr_addr      = count_reg[IDX_W-1:0];
        wr_data      = value;
        emit.valid   = 1'b0;
        emit.status  = report_reg;
        emit.element = '0;
        emit.last    = 1'b1;
        unique case (state_reg)
            S_IDLE:
            begin
                in_stall = 1'b0;
                idx_next = '0;
                if (accept)
                begin
                    if (command == CMD_INSERT)
                    begin
                        if (full)
                        begin
                            report_next = ST_FULL;
                        end
                        else
                        begin
                            report_next = ST_INSERTED;
                            wr_en       = 1'b1;
                            count_next  = count_reg + CNT_W'(1);
                        end
                    end
                    else
                    begin
                        report_next = ST_EMPTY;
                    end
                end
            end
            S_REPORT:
            begin
                emit.valid = emit_ready;
            end
            S_DEL_RD, S_SHF_RD, S_DISP_RD:
            begin
                rd_en = 1'b1;
            end
            S_DEL_CMP:
            begin
                if (ures.match && ures.at_end)
                begin
                    report_next = ST_DELETED;
                    count_next  = count_reg - CNT_W'(1);
                end
                else if (ures.at_end)
                begin
                    report_next = ST_NOT_FOUND;
                end
                else
                begin
                    idx_next = ures.idx_inc;
                end
            end
            S_SHF_WR:
            begin
                wr_en   = 1'b1;
                wr_addr = idx_reg - IDX_W'(1);
                wr_data = rdata_reg;
                if (ures.at_end)
                begin
                    report_next = ST_DELETED;
                    count_next  = count_reg - CNT_W'(1);
                end
                else
                begin
                    idx_next = ures.idx_inc;
                end
            end
            S_DISP_EMIT:
            begin
                emit.valid   = emit_ready;
                emit.status  = ST_ELEMENT;
                emit.element = rdata_reg;
                emit.last    = ures.at_end;
                if (emit_ready)
                    idx_next = ures.idx_inc;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            idx_reg    <= '0;
            count_reg  <= '0;
            report_reg <= ST_EMPTY;
        end
        else
        begin
            state_reg  <= state_next;
            idx_reg    <= idx_next;
            count_reg  <= count_next;
            report_reg <= report_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            value_reg <= value;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (rd_en)
            rdata_reg <= mem[idx_reg];
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("list length beyond capacity");

    a_idx_in_list: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE && state_reg != S_REPORT) |-> (CNT_W'(idx_reg) < count_reg))
        else $error("scan index outside the list");

    a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && command == CMD_INSERT && !full)
        |=> (count_reg == $past(count_reg) + CNT_W'(1)))
        else $error("insert did not grow the list");

    a_delete_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_REPORT && report_reg == ST_DELETED && emit_ready)
        |-> (count_reg < CNT_W'(CAPACITY)))
        else $error("delete left a full list");

endmodule

@@ rtl/ordered_list_insert_delete_top.sv @@
// top level of the ordered list insert/delete block
// depends on olid_pkg, olid_seq, olid_unit and olid_outreg
//
// keeps up to CAPACITY signed 32-bit values in insertion order
// input channel: in_valid/in_stall with command and value; one beat per command
// output channel: out_valid/out_stall with status, element and last
// insert appends at the tail or reports full; delete removes the first match
// from the head or reports not found / empty; display sends one beat per entry
// from the head, last set on the final one, or reports empty
// every command ends with a beat that has last set; command code 3 is dropped
// insert and empty cases pass through the report state to the output register;
// delete reads and compares each entry up to the match, then reads each later
// entry and writes it one place down to close the gap; display reads and then
// emits each entry (one memory read and one emit on the single read port)
// in_stall stays high from the accepted beat until its final result is handed
// to the output register; one command is worked on at a time
// a stalled output holds its beat and the sequencer waits on it
// reset clears the list length and the control state; entries need no clearing
module ordered_list_insert_delete_top
    import olid_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic [CMD_W-1:0]         command,
    input  logic signed [DATA_W-1:0] value,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic [STAT_W-1:0]        status,
    output logic signed [DATA_W-1:0] element,
    output logic                     last
);

    beat_t emit;
    logic  emit_ready;

    olid_seq u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .command    (command),
        .value      (value),
        .emit_ready (emit_ready),
        .emit       (emit)
    );

    olid_outreg u_outreg (
        .clk        (clk),
        .rst_n      (rst_n),
        .emit       (emit),
        .emit_ready (emit_ready),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .status     (status),
        .element    (element),
        .last       (last)
    );

endmodule

@@ dv/olid_list_checker.sv @@
// checker for the ordered list insert/delete block: watches both channels,
// keeps its own copy of the list, predicts every output beat and compares
// depends on olid_pkg
module olid_list_checker
    import olid_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    input  logic                     in_stall,
    input  logic [CMD_W-1:0]         command,
    input  logic signed [DATA_W-1:0] value,
    input  logic                     out_valid,
    input  logic                     out_stall,
    input  logic [STAT_W-1:0]        status,
    input  logic signed [DATA_W-1:0] element,
    input  logic                     last,
    output int                       mismatches,
    output int                       outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        status_t                  status;
        logic signed [DATA_W-1:0] element;
        logic                     last;
    } list_beat_t;

    logic signed [DATA_W-1:0] list_entries[$];
    list_beat_t               expected_beats[$];
    int                       fail_cnt = 0;
    int                       pend_cnt = 0;

    assign mismatches  = fail_cnt;
    assign outstanding = pend_cnt;

    function automatic list_beat_t outcome(status_t s, logic signed [DATA_W-1:0] e, logic l);
        list_beat_t b;
        b.status  = s;
        b.element = e;
        b.last    = l;
        return b;
    endfunction

    task automatic apply_command(input logic [CMD_W-1:0] cmd,
                                 input logic signed [DATA_W-1:0] val);
        int hit;
        hit = -1;
        case (cmd)
            CMD_INSERT:
            begin
                if (list_entries.size() >= CAPACITY)
                    expected_beats.push_back(outcome(ST_FULL, '0, 1'b1));
                else
                begin
                    list_entries.push_back(val);
                    expected_beats.push_back(outcome(ST_INSERTED, '0, 1'b1));
                end
            end
            CMD_DELETE:
            begin
                if (list_entries.size() == 0)
                    expected_beats.push_back(outcome(ST_EMPTY, '0, 1'b1));
                else
                begin
                    // first match from the head
                    for (int i = 0; i < list_entries.size(); i++)
                        if (hit < 0 && list_entries[i] == val)
                            hit = i;
                    if (hit < 0)
                        expected_beats.push_back(outcome(ST_NOT_FOUND, '0, 1'b1));
                    else
                    begin
                        list_entries.delete(hit);
                        expected_beats.push_back(outcome(ST_DELETED, '0, 1'b1));
                    end
                end
            end
            CMD_DISPLAY:
            begin
                if (list_entries.size() == 0)
                    expected_beats.push_back(outcome(ST_EMPTY, '0, 1'b1));
                else
                    for (int i = 0; i < list_entries.size(); i++)
                        expected_beats.push_back(outcome(ST_ELEMENT, list_entries[i],
                                                         i == list_entries.size() - 1));
            end
            default: ;
        endcase
    endtask

    task automatic check_beat();
        list_beat_t want;
        if (expected_beats.size() == 0)
        begin
            fail_cnt++;
            if (fail_cnt <= 10)
                $display("%0t: unexpected beat status %0d element %0d last %0b",
                         $realtime, status, element, last);
        end
        else
        begin
            want = expected_beats.pop_front();
            if (status !== want.status || element !== want.element || last !== want.last)
            begin
                fail_cnt++;
                if (fail_cnt <= 10)
                    $display({"%0t: beat mismatch expected status %0d element %0d",
                              " last %0b, got status %0d element %0d last %0b"},
                             $realtime, want.status, want.element, want.last,
                             status, element, last);
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            list_entries.delete();
            expected_beats.delete();
            pend_cnt <= 0;
        end
        else
        begin
            if (in_valid && !in_stall)
                apply_command(command, value);
            if (out_valid && !out_stall)
                check_beat();
            pend_cnt <= expected_beats.size();
        end
    end

endmodule

@@ dv/ordered_list_insert_delete_top_tb.sv @@
// testbench top for the ordered list insert/delete block: drives commands,
// stalls the output at random and gives the verdict
// depends on olid_pkg, olid_list_checker and the block's rtl
module ordered_list_insert_delete_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import olid_pkg::*;

    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam int HOLD_CYCLES  = 200;
    localparam int IDLE_LIMIT   = 2000;
    localparam int DRAIN_CYCLES = 2 * CAPACITY + 8;

    logic                     clk       = 1'b0;
    logic                     rst_n     = 1'b0;
    logic                     in_valid  = 1'b0;
    logic                     in_stall;
    logic [CMD_W-1:0]         command   = CMD_INSERT;
    logic signed [DATA_W-1:0] value     = '0;
    logic                     out_valid;
    logic                     out_stall = 1'b0;
    logic [STAT_W-1:0]        status;
    logic signed [DATA_W-1:0] element;
    logic                     last;

    int mismatches;
    int outstanding;
    int idle_cycles = 0;
    bit send_burst  = 1'b0;
    bit recv_burst  = 1'b0;
    bit hold_req    = 1'b0;

    always #6 clk = ~clk;

    ordered_list_insert_delete_top u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .command   (command),
        .value     (value),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .element   (element),
        .last      (last)
    );

    olid_list_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .command     (command),
        .value       (value),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .status      (status),
        .element     (element),
        .last        (last),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    task automatic send_cmd(input logic [CMD_W-1:0] c, input logic signed [DATA_W-1:0] v);
        int gap;
        if ($urandom_range(0, 7) == 0)
            send_burst = !send_burst;
        gap = send_burst ? 0 : $urandom_range(0, 10);
        if (gap > 0)
        begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid = 1'b1;
        command  = c;
        value    = v;
        do @(posedge clk); while (in_stall);
        @(negedge clk);
    endtask

    // mostly a small pool so deletes find matches, sometimes any value
    function automatic logic signed [DATA_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0: return 32'sh8000_0000;
            1: return 32'sh7fff_ffff;
            2: return 32'sd0;
            3: return -32'sd1;
            4: return 32'sd5;
            5: return -32'sd100;
            6: return 32'sd3;
            default: return $urandom;
        endcase
    endfunction

    task automatic run_phase(input int n, input bit insert_heavy);
        int done;
        int r;
        logic [CMD_W-1:0] c;
        done = 0;
        while (done < n)
        begin
            r = $urandom_range(0, 99);
            if (r < (insert_heavy ? 60 : 20))
                c = CMD_INSERT;
            else if (r < (insert_heavy ? 85 : 82))
                c = CMD_DELETE;
            else if (r < 97)
                c = CMD_DISPLAY;
            else
                c = CMD_UNUSED;
            send_cmd(c, pick_value());
            if (c != CMD_UNUSED)
                done++;
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles <= 0;
            else if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("Regression FAIL");
                $finish;
            end
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin
        int n;
        bit held;
        @(posedge rst_n);
        held = 1'b0;
        forever
        begin
            // long hold-off so the block backs up into its input
            if (hold_req && !held)
            begin
                out_stall = 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
                held = 1'b1;
            end
            if ($urandom_range(0, 7) == 0)
                recv_burst = !recv_burst;
            n = recv_burst ? 0 : $urandom_range(0, 10);
            if (n > 0)
            begin
                out_stall = 1'b1;
                repeat (n) @(negedge clk);
            end
            out_stall = 1'b0;
            do @(posedge clk); while (!out_valid);
            @(negedge clk);
        end
    end

    initial
    begin
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        send_cmd(CMD_DISPLAY, 32'sd0);
        send_cmd(CMD_DELETE, 32'sd7);
        send_cmd(CMD_INSERT, 32'sh8000_0000);
        send_cmd(CMD_INSERT, 32'sh7fff_ffff);
        send_cmd(CMD_INSERT, 32'sd0);
        send_cmd(CMD_INSERT, -32'sd1);
        send_cmd(CMD_DISPLAY, $urandom);
        send_cmd(CMD_DELETE, 32'sd12345);
        send_cmd(CMD_DELETE, 32'sd0);
        send_cmd(CMD_UNUSED, $urandom);
        // fill to capacity with duplicates
        repeat (CAPACITY - 3)
            send_cmd(CMD_INSERT, $urandom_range(0, 3));
        send_cmd(CMD_INSERT, 32'sd9);
        send_cmd(CMD_DISPLAY, 32'sd0);
        send_cmd(CMD_DELETE, 32'sh8000_0000);
        send_cmd(CMD_DELETE, 32'sd2);

        hold_req   = 1'b1;
        send_burst = 1'b1;
        run_phase(25, 1'b1);
        run_phase(25, 1'b0);
        run_phase(25, 1'b1);
        run_phase(25, 1'b0);
        in_valid = 1'b0;

        while (outstanding != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
